// File: sv/lfdr_pkg.sv
package lfdr_pkg;

    // fixed field widths
    localparam int CMD_W   = 3;
    localparam int ROW_W   = 3;
    localparam int COL_W   = 6;
    localparam int CHAR_W  = 8;
    localparam int BIDX_W  = 3;
    localparam int BUS_W   = 10;
    localparam int WAIT_W  = 11;
    localparam int CIDX_W  = 2;
    localparam int CDATA_W = 6;
    localparam int POS_W   = 9;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUT    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SETBIT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FLUSH  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FINISH = 3'd4;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_ROWS = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_COLS = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_OBC  = 2'd2;

    // bus word pieces
    localparam logic [CHAR_W-1:0] SPACE       = 8'h20;
    localparam logic [1:0]        PFX_CURSOR  = 2'b11;
    localparam logic [1:0]        PFX_CHAR    = 2'b01;
    localparam logic [1:0]        PFX_LATCH   = 2'b00;
    localparam logic [BUS_W-1:0]  WORD_DCLR   = 10'h001;
    localparam logic [WAIT_W-1:0] WAIT_CHAR   = 11'd20;
    localparam logic [WAIT_W-1:0] WAIT_DCLR   = 11'd1250;
    localparam logic [WAIT_W-1:0] WAIT_LATCH  = 11'd0;
    localparam logic [POS_W-1:0]  ROW_STRIDE  = 9'd48;
    localparam logic [POS_W-1:0]  ROW_FOLD    = 9'd168;
    localparam logic [ROW_W-1:0]  ROW_FOLD_AT = 3'd3;

    localparam logic TGT_DISPLAY = 1'b0;
    localparam logic TGT_LATCH   = 1'b1;

    typedef enum logic [3:0] {
        S_SWEEP,
        S_IDLE,
        S_DCLR,
        S_LATCH,
        S_RD,
        S_CMP,
        S_CRD,
        S_CEM,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [3:0]       rows;
        logic [COL_W-1:0] cols;
        logic [3:0]       obc;
    } t_cfg;

    typedef struct packed {
        logic              push;
        logic              fin;
        logic [BUS_W-1:0]  word;
        logic              target;
        logic [WAIT_W-1:0] wait_us;
    } t_emit;

endpackage

// File: sv/lfdr_ram.sv
module lfdr_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 160,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/lfdr_outq.sv
module lfdr_outq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lfdr_pkg::t_emit               i_emit,
    output logic                          o_rdy,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [lfdr_pkg::BUS_W-1:0]    o_bus_word,
    output logic                          o_target,
    output logic [lfdr_pkg::WAIT_W-1:0]   o_wait_us,
    output logic                          o_last
);

    import lfdr_pkg::*;

    // one word is held back until it is known whether it ends the item
    logic              r_pend_v, n_pend_v;
    logic [BUS_W-1:0]  r_pend_word;
    logic              r_pend_tgt;
    logic [WAIT_W-1:0] r_pend_wait;

    logic              r_ov, n_ov;
    logic [BUS_W-1:0]  r_ow;
    logic              r_ot;
    logic [WAIT_W-1:0] r_owt;
    logic              r_ol;

    logic out_free;
    logic move;

    assign out_free = !r_ov || !i_out_stall;
    assign o_rdy    = !r_pend_v || out_free;
    assign move     = r_pend_v && out_free && (i_emit.push || i_emit.fin);

    always_comb begin
        n_ov = r_ov && i_out_stall;
        if (move) begin
            n_ov = 1'b1;
        end
        n_pend_v = r_pend_v;
        if (i_emit.push) begin
            n_pend_v = 1'b1;
        end else if (i_emit.fin) begin
            n_pend_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov     <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_ov     <= n_ov;
            r_pend_v <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_ow  <= r_pend_word;
            r_ot  <= r_pend_tgt;
            r_owt <= r_pend_wait;
            r_ol  <= i_emit.fin;
        end
        if (i_emit.push) begin
            r_pend_word <= i_emit.word;
            r_pend_tgt  <= i_emit.target;
            r_pend_wait <= i_emit.wait_us;
        end
    end

    assign o_out_valid = r_ov;
    assign o_bus_word  = r_ow;
    assign o_target    = r_ot;
    assign o_wait_us   = r_owt;
    assign o_last      = r_ol;

endmodule

// File: sv/lfdr_seq.sv
module lfdr_seq #(
    parameter int MAX_ROWS = 4,
    parameter int MAX_COLS = 40,
    localparam int DEPTH   = MAX_ROWS * MAX_COLS,
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lfdr_pkg::t_cfg                i_cfg,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [lfdr_pkg::CMD_W-1:0]    i_command,
    input  logic [lfdr_pkg::ROW_W-1:0]    i_row,
    input  logic [lfdr_pkg::COL_W-1:0]    i_col,
    input  logic [lfdr_pkg::CHAR_W-1:0]   i_char_code,
    input  logic [lfdr_pkg::BIDX_W-1:0]   i_bit_index,
    input  logic                          i_bit_value,
    input  logic                          i_full_clear,
    input  logic                          i_rdy,
    output lfdr_pkg::t_emit               o_emit,
    output logic                          o_wk_we,
    output logic [AW-1:0]                 o_wk_waddr,
    output logic [lfdr_pkg::CHAR_W-1:0]   o_wk_wdata,
    output logic                          o_wk_re,
    output logic [AW-1:0]                 o_wk_raddr,
    input  logic [lfdr_pkg::CHAR_W-1:0]   i_wk_rdata,
    output logic                          o_sh_we,
    output logic [AW-1:0]                 o_sh_waddr,
    output logic [lfdr_pkg::CHAR_W-1:0]   o_sh_wdata,
    output logic                          o_sh_re,
    output logic [AW-1:0]                 o_sh_raddr,
    input  logic [lfdr_pkg::CHAR_W-1:0]   i_sh_rdata
);

    import lfdr_pkg::*;

    t_state            r_state, n_state;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [COL_W-1:0]  r_first, n_first;
    logic [COL_W-1:0]  r_lastd, n_lastd;
    logic [COL_W-1:0]  r_k, n_k;
    logic [1:0]        r_eq, n_eq;
    logic              r_inrun, n_inrun;
    logic              r_clr, n_clr;
    logic              r_clr_sh, n_clr_sh;
    logic [AW-1:0]     r_addr, n_addr;
    logic [CHAR_W-1:0] r_obits, n_obits;

    logic [3:0]        erows;
    logic [COL_W-1:0]  ecols;
    logic              accept;
    logic              row_ok;
    logic              put_ok;
    logic              scan_end;
    logic              rd_go;
    logic              diff;
    logic [AW-1:0]     put_addr;
    logic [AW-1:0]     scan_addr;
    logic [AW-1:0]     chr_addr;
    logic [POS_W-1:0]  pos;

    assign erows  = (i_cfg.rows < 4'(MAX_ROWS)) ? i_cfg.rows : 4'(MAX_ROWS);
    assign ecols  = (i_cfg.cols < COL_W'(MAX_COLS)) ? i_cfg.cols : COL_W'(MAX_COLS);
    assign accept = i_in_valid && (r_state == S_IDLE);
    assign row_ok = {1'b0, i_row} < erows;
    assign put_ok = row_ok && (i_col < ecols);

    // columns past the visible width are still copied, without output
    assign scan_end = r_col >= ecols;
    assign rd_go    = !(scan_end && r_inrun) && (r_col < COL_W'(MAX_COLS));
    assign diff     = i_wk_rdata != i_sh_rdata;

    assign put_addr  = AW'(int'(i_row) * MAX_COLS + int'(i_col));
    assign scan_addr = AW'(int'(r_row) * MAX_COLS + int'(r_col));
    assign chr_addr  = AW'(int'(r_row) * MAX_COLS + int'(r_k));

    always_comb begin
        pos = POS_W'(r_row) * ROW_STRIDE + POS_W'(r_col);
        if (r_row > ROW_FOLD_AT) begin
            pos = pos - ROW_FOLD;
        end
    end

    assign o_in_stall = r_state != S_IDLE;

    // next state
    always_comb begin
        n_state  = r_state;
        n_row    = r_row;
        n_col    = r_col;
        n_first  = r_first;
        n_lastd  = r_lastd;
        n_k      = r_k;
        n_eq     = r_eq;
        n_inrun  = r_inrun;
        n_clr    = r_clr;
        n_clr_sh = r_clr_sh;
        n_addr   = r_addr;
        n_obits  = r_obits;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_command)
                        CMD_SETBIT: begin
                            if ({1'b0, i_bit_index} < i_cfg.obc) begin
                                n_obits[i_bit_index] = i_bit_value;
                            end
                        end
                        CMD_CLEAR: begin
                            n_obits  = '0;
                            n_clr    = 1'b1;
                            n_clr_sh = i_full_clear;
                            n_addr   = '0;
                            n_state  = i_full_clear ? S_DCLR : S_SWEEP;
                        end
                        CMD_FLUSH: begin
                            if (row_ok) begin
                                n_row   = i_row;
                                n_col   = '0;
                                n_inrun = 1'b0;
                                n_eq    = '0;
                                n_state = S_RD;
                            end
                        end
                        CMD_FINISH: begin
                            if (i_cfg.obc != '0) begin
                                n_clr   = 1'b0;
                                n_state = S_LATCH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DCLR: begin
                if (i_rdy) begin
                    n_state = (i_cfg.obc != '0) ? S_LATCH : S_SWEEP;
                end
            end
            S_LATCH: begin
                if (i_rdy) begin
                    n_state = r_clr ? S_SWEEP : S_FIN;
                end
            end
            S_SWEEP: begin
                n_addr = r_addr + AW'(1);
                if (r_addr == AW'(DEPTH - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_RD: begin
                if (scan_end && r_inrun) begin
                    n_k     = r_first;
                    n_state = S_CRD;
                end else if (r_col >= COL_W'(MAX_COLS)) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (scan_end) begin
                    n_col   = r_col + COL_W'(1);
                    n_state = S_RD;
                end else if (!r_inrun) begin
                    if (!diff || i_rdy) begin
                        if (diff) begin
                            n_inrun = 1'b1;
                            n_first = r_col;
                            n_lastd = r_col;
                            n_eq    = '0;
                        end
                        n_col   = r_col + COL_W'(1);
                        n_state = S_RD;
                    end
                end else if (!diff) begin
                    n_col = r_col + COL_W'(1);
                    if (r_eq == 2'd2) begin
                        // third equal cell closes the run
                        n_k     = r_first;
                        n_state = S_CRD;
                    end else begin
                        n_eq    = r_eq + 2'd1;
                        n_state = S_RD;
                    end
                end else begin
                    n_lastd = r_col;
                    n_eq    = '0;
                    n_col   = r_col + COL_W'(1);
                    n_state = S_RD;
                end
            end
            S_CRD: begin
                n_state = S_CEM;
            end
            S_CEM: begin
                if (i_rdy) begin
                    if (r_k == r_lastd) begin
                        n_inrun = 1'b0;
                        n_state = S_RD;
                    end else begin
                        n_k     = r_k + COL_W'(1);
                        n_state = S_CRD;
                    end
                end
            end
            S_FIN: begin
                if (i_rdy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // memory controls and emitted words
    always_comb begin
        o_wk_we    = 1'b0;
        o_wk_waddr = put_addr;
        o_wk_wdata = i_char_code;
        o_wk_re    = 1'b0;
        o_wk_raddr = scan_addr;
        o_sh_we    = 1'b0;
        o_sh_waddr = scan_addr;
        o_sh_wdata = i_wk_rdata;
        o_sh_re    = 1'b0;
        o_sh_raddr = scan_addr;
        o_emit     = '0;
        case (r_state)
            S_IDLE: begin
                o_wk_we = accept && (i_command == CMD_PUT) && put_ok;
            end
            S_SWEEP: begin
                o_wk_we    = 1'b1;
                o_wk_waddr = r_addr;
                o_wk_wdata = SPACE;
                o_sh_we    = r_clr_sh;
                o_sh_waddr = r_addr;
                o_sh_wdata = SPACE;
            end
            S_DCLR: begin
                o_emit.push    = i_rdy;
                o_emit.word    = WORD_DCLR;
                o_emit.target  = TGT_DISPLAY;
                o_emit.wait_us = WAIT_DCLR;
            end
            S_LATCH: begin
                o_emit.push    = i_rdy;
                o_emit.word    = {PFX_LATCH, r_obits};
                o_emit.target  = TGT_LATCH;
                o_emit.wait_us = WAIT_LATCH;
            end
            S_RD: begin
                o_wk_re = rd_go;
                o_sh_re = rd_go;
            end
            S_CMP: begin
                o_sh_we        = diff;
                o_emit.push    = !scan_end && !r_inrun && diff && i_rdy;
                o_emit.word    = {PFX_CURSOR, pos[CHAR_W-1:0]};
                o_emit.target  = TGT_DISPLAY;
                o_emit.wait_us = WAIT_CHAR;
            end
            S_CRD: begin
                o_wk_re    = 1'b1;
                o_wk_raddr = chr_addr;
            end
            S_CEM: begin
                o_emit.push    = i_rdy;
                o_emit.word    = {PFX_CHAR, i_wk_rdata};
                o_emit.target  = TGT_DISPLAY;
                o_emit.wait_us = WAIT_CHAR;
            end
            S_FIN: begin
                o_emit.fin = i_rdy;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_SWEEP;
            r_addr   <= '0;
            r_clr    <= 1'b0;
            r_clr_sh <= 1'b1;
            r_inrun  <= 1'b0;
            r_eq     <= '0;
            r_obits  <= '0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_clr    <= n_clr;
            r_clr_sh <= n_clr_sh;
            r_inrun  <= n_inrun;
            r_eq     <= n_eq;
            r_obits  <= n_obits;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row   <= n_row;
        r_col   <= n_col;
        r_first <= n_first;
        r_lastd <= n_lastd;
        r_k     <= n_k;
    end

endmodule

// File: sv/lcd_framebuffer_diff_refresh_core.sv
// put and set-bit complete when accepted; a flush row reads and compares every column of MAX_COLS
//   and then re-reads each character word, through the single read port of each buffer
// clear sweeps all MAX_ROWS*MAX_COLS cells one per cycle; throughput: one command at a time
// each word waits in the output stage until the next word or the end of its command is
//   known, passing through the pending register and then the output register
// reset: synchronous, active low; a sweep over all MAX_ROWS*MAX_COLS cells then blanks both buffers
module lcd_framebuffer_diff_refresh_core #(
    parameter int MAX_ROWS = 4,
    parameter int MAX_COLS = 40
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lfdr_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [lfdr_pkg::CDATA_W-1:0]  i_cfg_data,
    // command channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [lfdr_pkg::CMD_W-1:0]    i_command,
    input  logic [lfdr_pkg::ROW_W-1:0]    i_row,
    input  logic [lfdr_pkg::COL_W-1:0]    i_col,
    input  logic [lfdr_pkg::CHAR_W-1:0]   i_char_code,
    input  logic [lfdr_pkg::BIDX_W-1:0]   i_bit_index,
    input  logic                          i_bit_value,
    input  logic                          i_full_clear,
    // bus word channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [lfdr_pkg::BUS_W-1:0]    o_bus_word,
    output logic                          o_target,
    output logic [lfdr_pkg::WAIT_W-1:0]   o_wait_us,
    output logic                          o_last
);

    import lfdr_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // configuration registers; the user must write them only while the block is quiet, the block does not enforce it
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rows <= 4'd4;
            r_cfg.cols <= 6'd40;
            r_cfg.obc  <= 4'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ROWS: r_cfg.rows <= i_cfg_data[3:0];
                CFG_COLS: r_cfg.cols <= i_cfg_data;
                CFG_OBC:  r_cfg.obc  <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // working and shown buffers, one cell per entry at row*MAX_COLS+col
    logic              wk_we, wk_re, sh_we, sh_re;
    logic [AW-1:0]     wk_waddr, wk_raddr, sh_waddr, sh_raddr;
    logic [CHAR_W-1:0] wk_wdata, wk_rdata, sh_wdata, sh_rdata;

    lfdr_ram #(
        .W     (CHAR_W),
        .DEPTH (DEPTH)
    ) u_working (
        .i_clk   (i_clk),
        .i_we    (wk_we),
        .i_waddr (wk_waddr),
        .i_wdata (wk_wdata),
        .i_re    (wk_re),
        .i_raddr (wk_raddr),
        .o_rdata (wk_rdata)
    );

    lfdr_ram #(
        .W     (CHAR_W),
        .DEPTH (DEPTH)
    ) u_shown (
        .i_clk   (i_clk),
        .i_we    (sh_we),
        .i_waddr (sh_waddr),
        .i_wdata (sh_wdata),
        .i_re    (sh_re),
        .i_raddr (sh_raddr),
        .o_rdata (sh_rdata)
    );

    // sequencer: one compare of working against shown per scanned cell
    t_emit emit;
    logic  q_rdy;

    lfdr_seq #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_row        (i_row),
        .i_col        (i_col),
        .i_char_code  (i_char_code),
        .i_bit_index  (i_bit_index),
        .i_bit_value  (i_bit_value),
        .i_full_clear (i_full_clear),
        .i_rdy        (q_rdy),
        .o_emit       (emit),
        .o_wk_we      (wk_we),
        .o_wk_waddr   (wk_waddr),
        .o_wk_wdata   (wk_wdata),
        .o_wk_re      (wk_re),
        .o_wk_raddr   (wk_raddr),
        .i_wk_rdata   (wk_rdata),
        .o_sh_we      (sh_we),
        .o_sh_waddr   (sh_waddr),
        .o_sh_wdata   (sh_wdata),
        .o_sh_re      (sh_re),
        .o_sh_raddr   (sh_raddr),
        .i_sh_rdata   (sh_rdata)
    );

    // output stage: holds one word back so that the final one can carry last
    lfdr_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_emit      (emit),
        .o_rdy       (q_rdy),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_bus_word  (o_bus_word),
        .o_target    (o_target),
        .o_wait_us   (o_wait_us),
        .o_last      (o_last)
    );

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import lfdr_pkg::*;

    // block geometry as built here
    localparam int NROWS  = 4;
    localparam int NCOLS  = 40;
    localparam int NCELLS = NROWS * NCOLS;

    // settling time once the last bus word is in: a clear sweeps every cell once
    localparam int SETTLE_CYCLES = 2 * NCELLS + 100;

    // commands the block ignores
    localparam logic [CMD_W-1:0] CMD_RESV_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RESV_LAST  = 3'd7;

    typedef struct packed {
        logic [BUS_W-1:0]  word;
        logic              target;
        logic [WAIT_W-1:0] wait_us;
        logic              last;
    } t_bus_xfer;

    // clock, reset and block ports
    logic                i_clk;
    logic                rst_n        = 1'b0;
    logic                cfg_valid    = 1'b0;
    logic                cfg_ready;
    logic [CIDX_W-1:0]   cfg_index    = CFG_ROWS;
    logic [CDATA_W-1:0]  cfg_data     = '0;
    logic                in_valid     = 1'b0;
    logic                in_stall;
    logic [CMD_W-1:0]    in_command   = CMD_PUT;
    logic [ROW_W-1:0]    in_row       = '0;
    logic [COL_W-1:0]    in_col       = '0;
    logic [CHAR_W-1:0]   in_char_code = '0;
    logic [BIDX_W-1:0]   in_bit_index = '0;
    logic                in_bit_value = 1'b0;
    logic                in_full_clear = 1'b0;
    logic                out_valid;
    logic                out_stall    = 1'b0;
    logic [BUS_W-1:0]    out_bus_word;
    logic                out_target;
    logic [WAIT_W-1:0]   out_wait_us;
    logic                out_last;

    // shadow of the display state and of the registers
    logic [CHAR_W-1:0]   working_cells [NCELLS];
    logic [CHAR_W-1:0]   shown_cells   [NCELLS];
    logic [7:0]          latch_bits    = '0;
    logic [3:0]          shadow_rows   = 4'd4;
    logic [COL_W-1:0]    shadow_cols   = 6'd40;
    logic [3:0]          shadow_obc    = 4'd0;

    // bus words still to come, oldest first
    t_bus_xfer           pending_bus_words [$];
    t_bus_xfer           oldest_word;

    int                  mismatch_count  = 0;
    int                  words_checked   = 0;
    int                  commands_sent   = 0;
    int                  register_writes = 0;

    // idling percentages for the current phase
    int                  gap_pct   = 0;
    int                  stall_pct = 0;
    int                  stall_left = 0;

    lcd_framebuffer_diff_refresh_core #(
        .MAX_ROWS(NROWS),
        .MAX_COLS(NCOLS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_command   (in_command),
        .i_row       (in_row),
        .i_col       (in_col),
        .i_char_code (in_char_code),
        .i_bit_index (in_bit_index),
        .i_bit_value (in_bit_value),
        .i_full_clear(in_full_clear),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_bus_word  (out_bus_word),
        .o_target    (out_target),
        .o_wait_us   (out_wait_us),
        .o_last      (out_last)
    );

    // 8 ns clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // hard limit on the whole run
    initial begin
        #12_000_000;
        $display("testbench failed");
        $finish;
    end

    // both buffers come out of reset full of spaces
    initial begin
        for (int k = 0; k < NCELLS; k++) begin
            working_cells[k] = SPACE;
            shown_cells[k]   = SPACE;
        end
    end

    // effective display size, clamped to the built size
    function automatic int eff_rows();
        return (int'(shadow_rows) < NROWS) ? int'(shadow_rows) : NROWS;
    endfunction

    function automatic int eff_cols();
        return (int'(shadow_cols) < NCOLS) ? int'(shadow_cols) : NCOLS;
    endfunction

    function automatic void queue_word(input logic [BUS_W-1:0] word, input logic target,
                                       input logic [WAIT_W-1:0] wait_us);
        t_bus_xfer xfer;
        xfer.word    = word;
        xfer.target  = target;
        xfer.wait_us = wait_us;
        xfer.last    = 1'b0;
        pending_bus_words.push_back(xfer);
    endfunction

    // works out the bus words one accepted command causes and updates the shadow state
    function automatic void predict_bus_words(input logic [CMD_W-1:0] cmd,
                                              input logic [ROW_W-1:0] row,
                                              input logic [COL_W-1:0] col,
                                              input logic [CHAR_W-1:0] ch,
                                              input logic [BIDX_W-1:0] bidx,
                                              input logic bval, input logic full);
        int queued_before;
        int base;
        int ncols;
        int c;
        int first;
        int lastd;
        int same;
        int pos;
        queued_before = pending_bus_words.size();
        base  = int'(row) * NCOLS;
        ncols = eff_cols();
        case (cmd)
            CMD_PUT: begin
                if (int'(row) < eff_rows() && int'(col) < ncols)
                    working_cells[base + int'(col)] = ch;
            end
            CMD_SETBIT: begin
                if (bidx < shadow_obc)
                    latch_bits[bidx] = bval;
            end
            CMD_CLEAR: begin
                for (int k = 0; k < NCELLS; k++)
                    working_cells[k] = SPACE;
                latch_bits = '0;
                if (full) begin
                    for (int k = 0; k < NCELLS; k++)
                        shown_cells[k] = SPACE;
                    queue_word(WORD_DCLR, TGT_DISPLAY, WAIT_DCLR);
                    if (shadow_obc != 0)
                        queue_word({PFX_LATCH, latch_bits}, TGT_LATCH, WAIT_LATCH);
                end
            end
            CMD_FLUSH: begin
                if (int'(row) < eff_rows()) begin
                    c = 0;
                    while (c < ncols) begin
                        if (working_cells[base + c] == shown_cells[base + c]) begin
                            c++;
                        end else begin
                            // a run stays open until three equal cells in a row
                            first = c;
                            lastd = c;
                            same  = 0;
                            pos   = int'(row) * int'(ROW_STRIDE) + c;
                            if (row > ROW_FOLD_AT)
                                pos -= int'(ROW_FOLD);
                            queue_word({PFX_CURSOR, 8'(pos)}, TGT_DISPLAY, WAIT_CHAR);
                            c++;
                            while (c < ncols) begin
                                if (working_cells[base + c] == shown_cells[base + c]) begin
                                    same++;
                                    if (same > 2)
                                        break;
                                end else begin
                                    lastd = c;
                                    same  = 0;
                                end
                                c++;
                            end
                            for (int k = first; k <= lastd; k++)
                                queue_word({PFX_CHAR, working_cells[base + k]},
                                           TGT_DISPLAY, WAIT_CHAR);
                            c++;
                        end
                    end
                    for (int k = 0; k < NCOLS; k++)
                        shown_cells[base + k] = working_cells[base + k];
                end
            end
            CMD_FINISH: begin
                if (shadow_obc != 0)
                    queue_word({PFX_LATCH, latch_bits}, TGT_LATCH, WAIT_LATCH);
            end
            default: begin
            end
        endcase
        if (pending_bus_words.size() > queued_before)
            pending_bus_words[pending_bus_words.size() - 1].last = 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("mismatch at %0t ns: %s got 0x%0h, expected 0x%0h", $time, what, got,
                 want);
    endtask

    // receiver stall: random bursts, none when stall_pct is zero
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            out_stall  = 1'b1;
            stall_left = stall_left - 1;
        end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
            out_stall  = 1'b1;
            stall_left = $urandom_range(17);
        end else begin
            out_stall = 1'b0;
        end
    end

    // every bus word transfer is compared with the oldest pending word
    always @(posedge i_clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_bus_words.size() == 0) begin
                report_mismatch("bus word with nothing pending", out_bus_word, 0);
            end else begin
                oldest_word = pending_bus_words.pop_front();
                words_checked++;
                if (out_bus_word !== oldest_word.word)
                    report_mismatch("bus word", out_bus_word, oldest_word.word);
                if (out_target !== oldest_word.target)
                    report_mismatch("target", out_target, oldest_word.target);
                if (out_wait_us !== oldest_word.wait_us)
                    report_mismatch("wait", out_wait_us, oldest_word.wait_us);
                if (out_last !== oldest_word.last)
                    report_mismatch("last flag", out_last, oldest_word.last);
            end
        end
    end

    // one command transfer, with an optional sender gap ahead of it
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [ROW_W-1:0] row,
                            input logic [COL_W-1:0] col, input logic [CHAR_W-1:0] ch,
                            input logic [BIDX_W-1:0] bidx, input logic bval,
                            input logic full);
        int gap;
        @(negedge i_clk);
        if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
            gap = $urandom_range(18, 1);
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_command    = cmd;
        in_row        = row;
        in_col        = col;
        in_char_code  = ch;
        in_bit_index  = bidx;
        in_bit_value  = bval;
        in_full_clear = full;
        in_valid      = 1'b1;
        do @(posedge i_clk); while (in_stall);
        predict_bus_words(cmd, row, col, ch, bidx, bval, full);
        commands_sent++;
    endtask

    // drop valid, let every pending word arrive, then let the block finish any sweep
    task automatic wait_for_idle();
        @(negedge i_clk);
        in_valid = 1'b0;
        while (pending_bus_words.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CIDX_W-1:0] idx,
                                  input logic [CDATA_W-1:0] value);
        @(negedge i_clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge i_clk); while (!cfg_ready);
        case (idx)
            CFG_ROWS: shadow_rows = value[3:0];
            CFG_COLS: shadow_cols = value;
            CFG_OBC:  shadow_obc  = value[3:0];
            default: begin
            end
        endcase
        register_writes++;
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    // reset sizes: range edges of put and flush, run splitting, ignored commands, clears
    task automatic test_directed_edges();
        send_cmd(CMD_PUT, 0, 0, 8'hFF, 0, 0, 0);
        send_cmd(CMD_PUT, 3, 39, 8'h00, 7, 1, 1);
        send_cmd(CMD_PUT, 4, 5, 8'h55, 0, 0, 0);
        send_cmd(CMD_PUT, 7, 63, 8'hAA, 0, 0, 0);
        send_cmd(CMD_PUT, 0, 40, 8'h33, 0, 0, 0);
        // one equal cell and two equal cells keep a run open, three close it
        send_cmd(CMD_PUT, 1, 2, 8'h78, 0, 0, 0);
        send_cmd(CMD_PUT, 1, 4, 8'h79, 0, 0, 0);
        send_cmd(CMD_PUT, 1, 7, 8'h7A, 0, 0, 0);
        send_cmd(CMD_PUT, 1, 11, 8'h7B, 0, 0, 0);
        // last column of a row
        send_cmd(CMD_PUT, 1, 39, 8'h21, 0, 0, 0);
        send_cmd(CMD_FLUSH, 0, 0, 0, 0, 0, 0);
        send_cmd(CMD_FLUSH, 1, 63, 8'hFF, 7, 1, 1);
        send_cmd(CMD_FLUSH, 3, 0, 0, 0, 0, 0);
        send_cmd(CMD_FLUSH, 4, 0, 0, 0, 0, 0);
        send_cmd(CMD_FLUSH, 7, 0, 0, 0, 0, 0);
        // nothing differs any more
        send_cmd(CMD_FLUSH, 1, 0, 0, 0, 0, 0);
        // no output bits at reset
        send_cmd(CMD_SETBIT, 0, 0, 0, 0, 1, 0);
        send_cmd(CMD_FINISH, 0, 0, 0, 0, 0, 0);
        for (int k = int'(CMD_RESV_FIRST); k <= int'(CMD_RESV_LAST); k++)
            send_cmd(CMD_W'(k), 3'($urandom), 6'($urandom), 8'($urandom), 3'($urandom),
                     1'($urandom), 1'($urandom));
        send_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
        send_cmd(CMD_FLUSH, 0, 0, 0, 0, 0, 0);
        send_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 1);
        send_cmd(CMD_PUT, 2, 20, 8'h41, 0, 0, 0);
        send_cmd(CMD_FLUSH, 2, 0, 0, 0, 0, 0);
    endtask

    // latch byte: bit counts, set and clear, clears zero it
    task automatic test_output_latch();
        wait_for_idle();
        write_register(CFG_OBC, 6'd8);
        send_cmd(CMD_SETBIT, 0, 0, 0, 7, 1, 0);
        send_cmd(CMD_SETBIT, 0, 0, 0, 0, 1, 0);
        send_cmd(CMD_SETBIT, 0, 0, 0, 3, 1, 0);
        send_cmd(CMD_FINISH, 0, 0, 0, 0, 0, 0);
        send_cmd(CMD_SETBIT, 0, 0, 0, 0, 0, 0);
        send_cmd(CMD_FINISH, 0, 0, 0, 0, 0, 0);
        send_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 1);
        send_cmd(CMD_SETBIT, 0, 0, 0, 2, 1, 0);
        send_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
        send_cmd(CMD_FINISH, 0, 0, 0, 0, 0, 0);
        wait_for_idle();
        write_register(CFG_OBC, 6'd3);
        send_cmd(CMD_SETBIT, 0, 0, 0, 5, 1, 0);
        send_cmd(CMD_SETBIT, 0, 0, 0, 2, 1, 0);
        send_cmd(CMD_FINISH, 0, 0, 0, 0, 0, 0);
        wait_for_idle();
        // all data bits high: count of fifteen
        write_register(CFG_OBC, 6'h3F);
        send_cmd(CMD_SETBIT, 0, 0, 0, 7, 1, 0);
        send_cmd(CMD_FINISH, 0, 0, 0, 0, 0, 0);
    endtask

    // zero sizes, sizes beyond the build, the smallest display and the top of the range
    task automatic test_register_extremes();
        wait_for_idle();
        write_register(CFG_ROWS, 6'd0);
        send_cmd(CMD_PUT, 0, 0, 8'h5A, 0, 0, 0);
        send_cmd(CMD_FLUSH, 0, 0, 0, 0, 0, 0);
        wait_for_idle();
        write_register(CFG_ROWS, 6'd4);
        write_register(CFG_COLS, 6'd0);
        send_cmd(CMD_PUT, 0, 0, 8'h5B, 0, 0, 0);
        send_cmd(CMD_FLUSH, 0, 0, 0, 0, 0, 0);
        wait_for_idle();
        write_register(CFG_ROWS, 6'h3F);
        write_register(CFG_COLS, 6'h3F);
        write_register(CFG_OBC, 6'd15);
        send_cmd(CMD_PUT, 3, 39, 8'h7E, 0, 0, 0);
        send_cmd(CMD_PUT, 3, 40, 8'h7F, 0, 0, 0);
        send_cmd(CMD_PUT, 4, 0, 8'h7D, 0, 0, 0);
        send_cmd(CMD_FLUSH, 3, 0, 0, 0, 0, 0);
        send_cmd(CMD_FLUSH, 4, 0, 0, 0, 0, 0);
        wait_for_idle();
        write_register(CFG_ROWS, 6'd1);
        write_register(CFG_COLS, 6'd1);
        write_register(CFG_OBC, 6'd1);
        send_cmd(CMD_PUT, 0, 0, 8'h31, 0, 0, 0);
        send_cmd(CMD_PUT, 0, 1, 8'h32, 0, 0, 0);
        send_cmd(CMD_PUT, 1, 0, 8'h33, 0, 0, 0);
        send_cmd(CMD_FLUSH, 0, 0, 0, 0, 0, 0);
        send_cmd(CMD_FLUSH, 1, 0, 0, 0, 0, 0);
        send_cmd(CMD_SETBIT, 0, 0, 0, 1, 1, 0);
        send_cmd(CMD_SETBIT, 0, 0, 0, 0, 1, 0);
        send_cmd(CMD_FINISH, 0, 0, 0, 0, 0, 0);
        wait_for_idle();
        write_register(CFG_ROWS, 6'd8);
        write_register(CFG_COLS, 6'd48);
        write_register(CFG_OBC, 6'd8);
        send_cmd(CMD_PUT, 2, 47, 8'h44, 0, 0, 0);
        send_cmd(CMD_PUT, 2, 0, 8'h45, 0, 0, 0);
        send_cmd(CMD_FLUSH, 2, 0, 0, 0, 0, 0);
    endtask

    // random settings, then mostly put bursts closed by a flush of the same row
    task automatic test_random_traffic(input int n, input int gap, input int stall);
        int sent;
        int pick;
        int r;
        int c0;
        int c;
        int span;
        logic [CHAR_W-1:0] ch;
        sent = 0;
        wait_for_idle();
        write_register(CFG_ROWS, ($urandom_range(9) == 0) ? 6'($urandom)
                                                          : 6'($urandom_range(8, 1)));
        write_register(CFG_COLS, ($urandom_range(9) == 0) ? 6'($urandom)
                                                          : 6'($urandom_range(48, 1)));
        write_register(CFG_OBC, 6'($urandom_range(8)));
        gap_pct   = gap;
        stall_pct = stall;
        while (sent < n) begin
            pick = $urandom_range(99);
            if (pick < 65 && eff_rows() > 0 && eff_cols() > 0) begin
                r    = $urandom_range(eff_rows() - 1);
                c0   = $urandom_range(eff_cols() - 1);
                span = $urandom_range(12);
                repeat ($urandom_range(8, 1)) begin
                    c = c0 + $urandom_range(span);
                    if (c >= eff_cols())
                        c = eff_cols() - 1;
                    // spaces and a small alphabet give cells equal to what is shown
                    case ($urandom_range(3))
                        0: ch = SPACE;
                        1: ch = 8'h41 + 8'($urandom_range(2));
                        default: ch = 8'($urandom);
                    endcase
                    send_cmd(CMD_PUT, 3'(r), 6'(c), ch, 3'($urandom), 1'($urandom),
                             1'($urandom));
                    sent++;
                end
                send_cmd(CMD_FLUSH, 3'(r), 6'($urandom), 8'($urandom), 3'($urandom),
                         1'($urandom), 1'($urandom));
                sent++;
            end else if (pick < 80) begin
                send_cmd(CMD_SETBIT, 3'($urandom), 6'($urandom), 8'($urandom),
                         3'($urandom), 1'($urandom), 1'($urandom));
                sent++;
                if ($urandom_range(1) == 0) begin
                    send_cmd(CMD_FINISH, 3'($urandom), 6'($urandom), 8'($urandom),
                             3'($urandom), 1'($urandom), 1'($urandom));
                    sent++;
                end
            end else if (pick < 88) begin
                // noise: any command, any field
                send_cmd(3'($urandom), 3'($urandom), 6'($urandom), 8'($urandom),
                         3'($urandom), 1'($urandom), 1'($urandom));
                sent++;
            end else if (pick < 93) begin
                send_cmd(CMD_CLEAR, 3'($urandom), 6'($urandom), 8'($urandom),
                         3'($urandom), 1'($urandom), 1'($urandom));
                sent++;
            end else begin
                // flush of any row, out of range ones included
                send_cmd(CMD_FLUSH, 3'($urandom), 6'($urandom), 8'($urandom),
                         3'($urandom), 1'($urandom), 1'($urandom));
                sent++;
            end
        end
    endtask

    initial begin
        rst_n = 1'b0;
        repeat (6) @(negedge i_clk);
        rst_n = 1'b1;
        test_directed_edges();
        test_output_latch();
        test_register_extremes();
        test_random_traffic(40, 20, 15);
        test_random_traffic(40, 5, 40);
        test_random_traffic(35, 12, 8);
        // closing stretch with neither side idling
        test_random_traffic(25, 0, 0);
        wait_for_idle();
        $display("covered %0d commands and %0d register writes over directed and random phases",
                 commands_sent, register_writes);
        $display("checked %0d bus words, %0d mismatches", words_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
